// File: rtl/core/vn2_pkg.sv
`default_nettype none
package vn2_pkg;

	// field widths at the block ports
	localparam int FIELD_WIDTH = 16;
	localparam int OUT_WIDTH   = 16;
	localparam int SCALE_WIDTH = 8;

	// only the low COORD_WIDTH bits of a coordinate count
	localparam int COORD_WIDTH = 16;
	localparam int CW = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;

	localparam logic [SCALE_WIDTH-1:0] CELL_SCALE_RESET = SCALE_WIDTH'(12);

	// lattice hash constants
	localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
	localparam int HASH_SHIFT_A  = 13;
	localparam int HASH_SHIFT_B  = 16;
	localparam int LATTICE_WIDTH = 8;

	// blend numerator is at most 255*s*s
	localparam int NUM_WIDTH = LATTICE_WIDTH + 2 * SCALE_WIDTH;
	// quotient of 256*N/(255*s*s) is at most 256
	localparam int QUOT_BITS = 9;
	localparam int DIV_WIDTH = NUM_WIDTH + QUOT_BITS - 1;
	localparam logic [OUT_WIDTH-1:0] NOISE_MAX = OUT_WIDTH'(256);

	// queue between front and back, depth a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

	// pipeline depths
	localparam int FRONT_STAGES = CW + 1;
	localparam int BACK_STAGES  = 6 + QUOT_BITS;
	localparam int MAX_INFLIGHT = FRONT_STAGES + QUEUE_DEPTH + BACK_STAGES;
	localparam int INFLIGHT_WIDTH = $clog2(MAX_INFLIGHT + 1);

	// lattice cell and position inside it
	typedef struct packed {
		logic [CW-1:0]          gx;
		logic [CW-1:0]          gy;
		logic [SCALE_WIDTH-1:0] rx;
		logic [SCALE_WIDTH-1:0] ry;
	} vn2_cell_t;

endpackage
`default_nettype wire

// File: rtl/core/vn2_if.sv
`default_nettype none
// coordinate item channel
interface vn2_coord_if import vn2_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] x_coord;
	logic [FIELD_WIDTH-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

// noise result channel
interface vn2_noise_if import vn2_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_WIDTH-1:0] noise_q8_8;

	modport source (output valid, output noise_q8_8, input ready);
	modport sink (input valid, input noise_q8_8, output ready);
endinterface

// cell scale write channel
interface vn2_cfg_if import vn2_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SCALE_WIDTH-1:0] cell_scale;

	modport source (output valid, output cell_scale, input ready);
	modport sink (input valid, input cell_scale, output ready);
endinterface
`default_nettype wire

// File: rtl/core/vn2_front.sv
`default_nettype none
module vn2_front import vn2_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SCALE_WIDTH-1:0] scale,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FIELD_WIDTH-1:0] x_coord,
	input  logic [FIELD_WIDTH-1:0] y_coord,
	output logic                   out_valid,
	input  logic                   out_ready,
	output vn2_cell_t              out_cell
);

	logic                   adv;
	logic [CW:0]            vld_s;
	logic [CW-1:0]          coord_in [0:1];
	logic [CW-1:0]          num_s    [0:CW][0:1];
	logic [SCALE_WIDTH-1:0] rem_s    [0:CW][0:1];
	logic [SCALE_WIDTH:0]   trial    [0:CW-1][0:1];
	logic                   ge       [0:CW-1][0:1];

	assign adv      = !vld_s[CW] || out_ready;
	assign in_ready = adv;

	always_comb begin
		coord_in[0] = x_coord[CW-1:0];
		coord_in[1] = y_coord[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[CW-1:0], in_valid};
		end
	end

	// one quotient bit per stage, both lanes side by side
	always_comb begin
		for (int k = 0; k < CW; k++) begin
			for (int l = 0; l < 2; l++) begin
				trial[k][l] = {rem_s[k][l], num_s[k][l][CW-1]};
				ge[k][l]    = trial[k][l] >= {1'b0, scale};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				num_s[0][l] <= coord_in[l];
				rem_s[0][l] <= '0;
			end
			for (int k = 0; k < CW; k++) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k+1][l] <= ge[k][l] ? SCALE_WIDTH'(trial[k][l] - {1'b0, scale})
					                          : trial[k][l][SCALE_WIDTH-1:0];
					num_s[k+1][l] <= {num_s[k][l][CW-2:0], ge[k][l]};
				end
			end
		end
	end

	assign out_valid   = vld_s[CW];
	assign out_cell.gx = num_s[CW][0];
	assign out_cell.gy = num_s[CW][1];
	assign out_cell.rx = rem_s[CW][0];
	assign out_cell.ry = rem_s[CW][1];

endmodule
`default_nettype wire

// File: rtl/core/vn2_queue.sv
`default_nettype none
module vn2_queue import vn2_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  vn2_cell_t push_cell,
	output logic      pop_valid,
	input  logic      pop_ready,
	output vn2_cell_t pop_cell
);

	vn2_cell_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0] wr_ptr_q;
	logic [QPTR_WIDTH-1:0] rd_ptr_q;
	logic [QPTR_WIDTH:0]   count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = count_q != (QPTR_WIDTH+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cell   = mem_q[rd_ptr_q];

	// pointers wrap on their own since the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cell;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/vn2_back.sv
`default_nettype none
module vn2_back import vn2_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SCALE_WIDTH-1:0] scale,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  vn2_cell_t              in_cell,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_WIDTH-1:0]   noise_q8_8
);

	localparam int MIX_WIDTH = HASH_SHIFT_B + LATTICE_WIDTH;
	localparam int WGT_WIDTH = 2 * SCALE_WIDTH;
	localparam int PRD_WIDTH = LATTICE_WIDTH + WGT_WIDTH;
	// corner order: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
	localparam logic [31:0] CORNER_OFS [4] = '{
		32'd0, HASH_MUL_X, HASH_MUL_Y, HASH_MUL_X + HASH_MUL_Y
	};

	logic                     adv;
	logic [BACK_STAGES-1:0]   vld_s;

	logic [31:0]              px_s1, py_s1;
	logic [SCALE_WIDTH-1:0]   rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3;
	logic [31:0]              h_s2 [4];
	logic [MIX_WIDTH-1:0]     m_s3 [4];
	logic [LATTICE_WIDTH-1:0] c_s4 [4];
	logic [WGT_WIDTH-1:0]     w_s4 [4];
	logic [PRD_WIDTH-1:0]     p_s5 [4];
	logic [DIV_WIDTH-1:0]     rem_s [0:QUOT_BITS];
	logic [QUOT_BITS-1:0]     quo_s [0:QUOT_BITS];

	logic [WGT_WIDTH-1:0]     ssq_q;
	logic [NUM_WIDTH-1:0]     den_q;

	logic [31:0]              t [4];
	logic [MIX_WIDTH-1:0]     mix [4];
	logic [LATTICE_WIDTH-1:0] cv [4];
	logic [SCALE_WIDTH-1:0]   sx, sy;
	logic [NUM_WIDTH+1:0]     nsum;
	logic [DIV_WIDTH-1:0]     dsh [0:QUOT_BITS-1];
	logic                     dge [0:QUOT_BITS-1];

	assign adv      = !vld_s[BACK_STAGES-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[BACK_STAGES-2:0], in_valid};
		end
	end

	// divisor 255*s*s, registered through ssq_q and then den_q after a scale change
	always_ff @(posedge clk) begin
		ssq_q <= scale * scale;
		den_q <= {ssq_q, 8'd0} - {8'd0, ssq_q};
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			t[c]   = h_s2[c] ^ 32'($signed(h_s2[c]) >>> HASH_SHIFT_A);
			// only the low bits of the mix product reach the corner value
			mix[c] = MIX_WIDTH'(t[c][MIX_WIDTH-1:0] * HASH_MUL_MIX[MIX_WIDTH-1:0]);
			cv[c]  = m_s3[c][LATTICE_WIDTH-1:0]
			       ^ m_s3[c][HASH_SHIFT_B +: LATTICE_WIDTH];
		end
		sx   = scale - rx_s3;
		sy   = scale - ry_s3;
		nsum = (NUM_WIDTH+2)'(p_s5[0]) + (NUM_WIDTH+2)'(p_s5[1])
		     + (NUM_WIDTH+2)'(p_s5[2]) + (NUM_WIDTH+2)'(p_s5[3]);
		for (int j = 0; j < QUOT_BITS; j++) begin
			dsh[j] = DIV_WIDTH'(den_q) << (QUOT_BITS - 1 - j);
			dge[j] = rem_s[j] >= dsh[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// hash products of the base corner
			px_s1 <= 32'(in_cell.gx) * HASH_MUL_X;
			py_s1 <= 32'(in_cell.gy) * HASH_MUL_Y;
			rx_s1 <= in_cell.rx;
			ry_s1 <= in_cell.ry;
			// neighbor corners differ by the multiplier itself
			for (int c = 0; c < 4; c++) begin
				h_s2[c] <= px_s1 + py_s1 + CORNER_OFS[c];
			end
			rx_s2 <= rx_s1;
			ry_s2 <= ry_s1;
			for (int c = 0; c < 4; c++) begin
				m_s3[c] <= mix[c];
			end
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			for (int c = 0; c < 4; c++) begin
				c_s4[c] <= cv[c];
			end
			w_s4[0] <= sx * sy;
			w_s4[1] <= rx_s3 * sy;
			w_s4[2] <= sx * ry_s3;
			w_s4[3] <= rx_s3 * ry_s3;
			for (int c = 0; c < 4; c++) begin
				p_s5[c] <= c_s4[c] * w_s4[c];
			end
			rem_s[0] <= {nsum[NUM_WIDTH-1:0], (QUOT_BITS-1)'(0)};
			quo_s[0] <= '0;
			// restoring division, one quotient bit per stage
			for (int j = 0; j < QUOT_BITS; j++) begin
				rem_s[j+1] <= dge[j] ? rem_s[j] - dsh[j] : rem_s[j];
				quo_s[j+1] <= {quo_s[j][QUOT_BITS-2:0], dge[j]};
			end
		end
	end

	assign out_valid  = vld_s[BACK_STAGES-1];
	assign noise_q8_8 = OUT_WIDTH'(quo_s[QUOT_BITS]);

endmodule
`default_nettype wire

// File: rtl/core/value_noise_2d.sv
// Two-dimensional bilinear value noise. Each coordinate item (x_coord, y_coord) yields one
// result item noise_q8_8 = floor(256 * blend), where blend in [0, 1] is the bilinear mix of
// the four hashed lattice corners of the cell that holds the point; results therefore run
// from 0 to 256. The cell size comes from the cell_scale register (reset 12, a value of zero
// acts as one); write it only while no item is in flight. The block takes one item per clock
// cycle sustained while the result side does not stall: every step is a pipeline stage, the
// coordinate split produces one quotient bit per stage and the final normalization one result
// bit per stage. An item passes the coordinate divider, the queue and the hash, blend and
// division stages in that order. A four-entry queue between the coordinate divider and the
// hash and blend pipeline lets either side stall independently; results come out in order.
`default_nettype none
module value_noise_2d import vn2_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	vn2_coord_if.sink   coord,
	vn2_cfg_if.sink     cfg,
	vn2_noise_if.source noise
);

	logic [SCALE_WIDTH-1:0] cell_scale_q;
	logic [SCALE_WIDTH-1:0] scale_eff;

	// front to queue
	logic      fq_valid;
	logic      fq_ready;
	vn2_cell_t fq_cell;
	// queue to back
	logic      qb_valid;
	logic      qb_ready;
	vn2_cell_t qb_cell;

	// cell scale register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_scale_q <= CELL_SCALE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cell_scale_q <= cfg.cell_scale;
		end
	end

	// zero scale behaves as one
	assign scale_eff = (cell_scale_q == '0) ? SCALE_WIDTH'(1) : cell_scale_q;

	// front: split coordinates into lattice cell and remainder
	vn2_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (scale_eff),
		.in_valid  (coord.valid),
		.in_ready  (coord.ready),
		.x_coord   (coord.x_coord),
		.y_coord   (coord.y_coord),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_cell  (fq_cell)
	);

	// decoupling queue
	vn2_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cell  (fq_cell),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cell   (qb_cell)
	);

	// back: corner hash, bilinear blend, normalize to q8.8
	vn2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale      (scale_eff),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_cell    (qb_cell),
		.out_valid  (noise.valid),
		.out_ready  (noise.ready),
		.noise_q8_8 (noise.noise_q8_8)
	);

endmodule
`default_nettype wire

// File: rtl/core/vn2_checker.sv
`default_nettype none
module vn2_checker import vn2_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 coord_valid,
	input logic                 coord_ready,
	input logic                 noise_valid,
	input logic                 noise_ready,
	input logic [OUT_WIDTH-1:0] noise_q8_8
);

	logic                      in_acc;
	logic                      out_acc;
	logic [INFLIGHT_WIDTH-1:0] inflight_q;

	assign in_acc  = coord_valid && coord_ready;
	assign out_acc = noise_valid && noise_ready;

	// items accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + INFLIGHT_WIDTH'(in_acc) - INFLIGHT_WIDTH'(out_acc);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && !noise_ready |=> noise_valid && $stable(noise_q8_8))
		else $error("result changed while stalled");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> noise_q8_8 <= NOISE_MAX)
		else $error("noise above one in q8.8");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> inflight_q != '0)
		else $error("result without an item in flight");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= INFLIGHT_WIDTH'(MAX_INFLIGHT))
		else $error("more items in flight than storage");

endmodule

bind value_noise_2d vn2_checker u_vn2_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.coord_valid (coord.valid),
	.coord_ready (coord.ready),
	.noise_valid (noise.valid),
	.noise_ready (noise.ready),
	.noise_q8_8  (noise.noise_q8_8)
);
`default_nettype wire
